// ----- rtl/ppm_p6_stream_decoder_unit_defines.svh -----
// Assertion macros for the PPM P6 stream decoder.
// Used by the top level; no other dependencies.
`ifndef PPM_P6_STREAM_DECODER_UNIT_DEFINES_SVH
`define PPM_P6_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property: whenever cond holds, expr holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");
// Property: cond never holds.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/ppmp6_pkg.sv -----
// Shared types, codes and constants for the PPM P6 stream decoder.
// No dependencies; imported by every module of the block.
package ppmp6_pkg;

  // Request queue between parser and scaler
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Header number limit
  localparam logic [19:0] MAX_PARAM = 20'd65535;

  // Byte codes
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_6     = 8'h36;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [1:0] CH_BLUE   = 2'd2;
  localparam logic [7:0] SAT_VALUE = 8'd255;

  typedef enum logic [3:0] {
    PH_MAGIC_P = 4'd0,
    PH_MAGIC_6 = 4'd1,
    PH_WS_REQ  = 4'd2,
    PH_WS_W    = 4'd3,
    PH_DIG_W   = 4'd4,
    PH_WS_H    = 4'd5,
    PH_DIG_H   = 4'd6,
    PH_WS_M    = 4'd7,
    PH_DIG_M   = 4'd8,
    PH_DATA    = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ERR_MAGIC  = 3'd0,
    ERR_WS     = 3'd1,
    ERR_DIGIT  = 3'd2,
    ERR_ZERO   = 3'd3,
    ERR_LIMIT  = 3'd4,
    ERR_LENGTH = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_DIV,
    SC_DONE
  } sc_state_t;

  // One queued request: a raw sample to scale or an error report
  typedef struct packed {
    logic        is_err;
    err_code_t   code;
    logic [15:0] sample;
    logic [1:0]  channel;
    logic        eor;
    logic        eoi;
    logic [15:0] maxval;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CHAR_0) && (b <= CHAR_9);
  endfunction

endpackage

// ----- rtl/ppmp6_parser.sv -----
// Front end: header parser and sample assembler, one byte per cycle while the queue has room.
// Depends on ppmp6_pkg; feeds requests into ppmp6_fifo.
module ppmp6_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              byte_value,
  input  logic                    last_byte,
  input  ppmp6_pkg::fifo_status_t q_status,
  output logic                    q_wr,
  output ppmp6_pkg::item_t        q_item
);
  import ppmp6_pkg::*;

  phase_t      phase, phase_next;
  logic        err_latched, err_latched_next;
  logic [15:0] acc, acc_next;
  logic [15:0] width, width_next;
  logic [15:0] height, height_next;
  logic [15:0] maxval, maxval_next;
  logic [15:0] col, col_next;
  logic [15:0] row, row_next;
  logic [1:0]  chan, chan_next;
  logic [7:0]  hold, hold_next;
  logic        pending, pending_next;

  logic        accept;
  logic        emit;
  logic        raise;
  err_code_t   code;
  logic [15:0] sample;
  logic        eor;
  logic        eoi;
  logic        wide;
  logic [3:0]  digit;
  logic [19:0] acc_wide;
  logic [16:0] col_inc;
  logic [16:0] row_inc;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign digit    = byte_value[3:0] - CHAR_0[3:0];
  assign acc_wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, digit};
  assign wide     = (maxval[15:8] != 8'd0);
  assign col_inc  = {1'b0, col} + 17'd1;
  assign row_inc  = {1'b0, row} + 17'd1;

  // Classify the byte and work out the next parse state
  always_comb begin
    phase_next       = phase;
    err_latched_next = err_latched;
    acc_next         = acc;
    width_next       = width;
    height_next      = height;
    maxval_next      = maxval;
    col_next         = col;
    row_next         = row;
    chan_next        = chan;
    hold_next        = hold;
    pending_next     = pending;
    emit             = 1'b0;
    raise            = 1'b0;
    code             = ERR_MAGIC;
    sample           = 16'd0;
    eor              = 1'b0;
    eoi              = 1'b0;
    if (!err_latched) begin
      case (phase)
        PH_MAGIC_P, PH_MAGIC_6: begin
          if (byte_value != ((phase == PH_MAGIC_P) ? CHAR_P : CHAR_6)) begin
            raise = 1'b1;
            code  = ERR_MAGIC;
          end else if (last_byte) begin
            raise = 1'b1;
            code  = ERR_LENGTH;
          end else begin
            phase_next = (phase == PH_MAGIC_P) ? PH_MAGIC_6 : PH_WS_REQ;
          end
        end
        PH_WS_REQ: begin
          if (!is_ws(byte_value)) begin
            raise = 1'b1;
            code  = ERR_WS;
          end else if (last_byte) begin
            raise = 1'b1;
            code  = ERR_LENGTH;
          end else begin
            phase_next = PH_WS_W;
          end
        end
        PH_WS_W, PH_WS_H, PH_WS_M: begin
          // Skip whitespace, then the first digit opens the number
          if (is_ws(byte_value)) begin
            if (last_byte) begin
              raise = 1'b1;
              code  = ERR_LENGTH;
            end
          end else if (!is_digit(byte_value)) begin
            raise = 1'b1;
            code  = ERR_DIGIT;
          end else if (last_byte) begin
            raise = 1'b1;
            code  = ERR_LENGTH;
          end else begin
            acc_next = {12'd0, digit};
            case (phase)
              PH_WS_W: phase_next = PH_DIG_W;
              PH_WS_H: phase_next = PH_DIG_H;
              default: phase_next = PH_DIG_M;
            endcase
          end
        end
        PH_DIG_W, PH_DIG_H, PH_DIG_M: begin
          if (is_ws(byte_value)) begin
            // Close the number and store it
            if (acc == 16'd0) begin
              raise = 1'b1;
              code  = ERR_ZERO;
            end else if (last_byte) begin
              raise = 1'b1;
              code  = ERR_LENGTH;
            end else begin
              acc_next = 16'd0;
              case (phase)
                PH_DIG_W: begin
                  width_next = acc;
                  phase_next = PH_WS_H;
                end
                PH_DIG_H: begin
                  height_next = acc;
                  phase_next  = PH_WS_M;
                end
                default: begin
                  maxval_next = acc;
                  phase_next  = PH_DATA;
                end
              endcase
            end
          end else if (!is_digit(byte_value)) begin
            raise = 1'b1;
            code  = ERR_DIGIT;
          end else if (acc_wide > MAX_PARAM) begin
            raise = 1'b1;
            code  = ERR_LIMIT;
          end else if (last_byte) begin
            raise = 1'b1;
            code  = ERR_LENGTH;
          end else begin
            acc_next = acc_wide[15:0];
          end
        end
        PH_DATA: begin
          if (wide && !pending) begin
            // Hold the high byte of a two-byte sample
            if (last_byte) begin
              raise = 1'b1;
              code  = ERR_LENGTH;
            end else begin
              hold_next    = byte_value;
              pending_next = 1'b1;
            end
          end else begin
            sample       = wide ? {hold, byte_value} : {8'd0, byte_value};
            pending_next = 1'b0;
            eor          = (chan == CH_BLUE) && (col_inc >= {1'b0, width});
            eoi          = eor && (row_inc >= {1'b0, height});
            if (last_byte && !eoi) begin
              raise = 1'b1;
              code  = ERR_LENGTH;
            end else begin
              emit = 1'b1;
              if (eoi) begin
                phase_next = PH_DONE;
              end else if (chan == CH_BLUE) begin
                chan_next = 2'd0;
                if (eor) begin
                  col_next = 16'd0;
                  row_next = row_inc[15:0];
                end else begin
                  col_next = col_inc[15:0];
                end
              end else begin
                chan_next = chan + 2'd1;
              end
            end
          end
        end
        default: begin
          // Any byte after the final sample is one too many
          raise = 1'b1;
          code  = ERR_LENGTH;
        end
      endcase
    end
    if (raise) begin
      emit             = 1'b1;
      err_latched_next = 1'b1;
    end
  end

  // Build the queue request
  assign q_wr           = accept && emit;
  assign q_item.is_err  = raise;
  assign q_item.code    = raise ? code : ERR_MAGIC;
  assign q_item.sample  = raise ? 16'd0 : sample;
  assign q_item.channel = raise ? 2'd0 : chan;
  assign q_item.eor     = raise ? 1'b0 : eor;
  assign q_item.eoi     = raise ? 1'b0 : eoi;
  assign q_item.maxval  = maxval;

  // Advance parse state; a last byte returns to the start of a file
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= PH_MAGIC_P;
      err_latched <= 1'b0;
      acc         <= 16'd0;
      width       <= 16'd0;
      height      <= 16'd0;
      maxval      <= 16'd0;
      col         <= 16'd0;
      row         <= 16'd0;
      chan        <= 2'd0;
      hold        <= 8'd0;
      pending     <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      err_latched <= err_latched_next;
      acc         <= acc_next;
      width       <= width_next;
      height      <= height_next;
      maxval      <= maxval_next;
      col         <= col_next;
      row         <= row_next;
      chan        <= chan_next;
      hold        <= hold_next;
      pending     <= pending_next;
    end
  end

endmodule

// ----- rtl/ppmp6_fifo.sv -----
// Short request queue between the parser and the scaler.
// Depends on ppmp6_pkg for the request type and depth.
module ppmp6_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr,
  input  ppmp6_pkg::item_t        wr_item,
  input  logic                    rd,
  output ppmp6_pkg::item_t        rd_item,
  output ppmp6_pkg::fifo_status_t status
);
  import ppmp6_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign rd_item      = mem[rd_ptr];

  // Store a request
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ppmp6_scaler.sv -----
// Back end: scales samples to 8 bits with a bit-serial restoring divider.
// Depends on ppmp6_pkg; pops requests from ppmp6_fifo.
module ppmp6_scaler (
  input  logic                    clk,
  input  logic                    rst,
  input  ppmp6_pkg::fifo_status_t q_status,
  input  ppmp6_pkg::item_t        q_item,
  output logic                    q_rd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    kind,
  output logic [7:0]              sample_value,
  output logic [1:0]              channel,
  output logic                    end_of_row,
  output logic                    end_of_image,
  output logic [2:0]              error_code
);
  import ppmp6_pkg::*;

  sc_state_t   state, state_next;
  item_t       item;
  logic [23:0] rem;
  logic [23:0] dreg;
  logic [7:0]  quo;
  logic [2:0]  step;
  logic        sat;

  logic [23:0] dividend;
  logic        fits;

  // sample * 255 without a multiplier
  assign dividend = {q_item.sample, 8'd0} - {8'd0, q_item.sample};
  assign fits     = (rem >= dreg);

  // Sequence: pop, divide (samples only; errors skip it), present
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    out_valid  = 1'b0;
    case (state)
      SC_IDLE: begin
        if (!q_status.empty) begin
          q_rd       = 1'b1;
          state_next = q_item.is_err ? SC_DONE : SC_DIV;
        end
      end
      SC_DIV: begin
        if (step == 3'd0) begin
          state_next = SC_DONE;
        end
      end
      SC_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = SC_IDLE;
        end
      end
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == SC_IDLE && !q_status.empty) begin
      item <= q_item;
      rem  <= dividend;
      dreg <= {1'b0, q_item.maxval, 7'd0};
      sat  <= (dividend >= {q_item.maxval, 8'd0});
      quo  <= 8'd0;
      step <= 3'd7;
    end else if (state == SC_DIV) begin
      if (fits) begin
        rem <= rem - dreg;
      end
      quo  <= {quo[6:0], fits};
      dreg <= dreg >> 1;
      step <= step - 3'd1;
    end
  end

  // Present the result
  assign kind         = item.is_err;
  assign sample_value = item.is_err ? 8'd0 : (sat ? SAT_VALUE : quo);
  assign channel      = item.channel;
  assign end_of_row   = item.eor;
  assign end_of_image = item.eoi;
  assign error_code   = item.code;

endmodule

// ----- rtl/ppm_p6_stream_decoder_unit.sv -----
// PPM P6 stream decoder. Header bytes give no result; a sample is written to the queue,
// popped into the scaler, divided and then presented; an error skips the divide step.
// Throughput: one byte per cycle while the 4-entry queue has room; the scaler's
// restoring divider (8 steps, one quotient bit a cycle) works on one sample at a time.
// Reset: synchronous rst returns the parser to expect 'P', empties the queue and
// idles the scaler; an accepted last byte also returns the parser to expect 'P'.
`include "ppm_p6_stream_decoder_unit_defines.svh"

module ppm_p6_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] sample_value, [9:8] channel, [10] end_of_row, [13:11] error_code, [15:14] zero
  output logic [15:0] m_tdata,
  output logic        m_tlast,   // end_of_image
  output logic        m_tuser    // kind
);
  import ppmp6_pkg::*;

  fifo_status_t q_status;
  item_t        wr_item;
  item_t        rd_item;
  logic         q_wr;
  logic         q_rd;
  logic         kind;
  logic [7:0]   sample_value;
  logic [1:0]   channel;
  logic         end_of_row;
  logic         end_of_image;
  logic [2:0]   error_code;

  ppmp6_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .byte_value (s_tdata),
    .last_byte  (s_tlast),
    .q_status   (q_status),
    .q_wr       (q_wr),
    .q_item     (wr_item)
  );

  ppmp6_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .rd      (q_rd),
    .rd_item (rd_item),
    .status  (q_status)
  );

  ppmp6_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_item       (rd_item),
    .q_rd         (q_rd),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .kind         (kind),
    .sample_value (sample_value),
    .channel      (channel),
    .end_of_row   (end_of_row),
    .end_of_image (end_of_image),
    .error_code   (error_code)
  );

  // Pack the result
  assign m_tdata = {2'b00, error_code, end_of_row, channel, sample_value};
  assign m_tlast = end_of_image;
  assign m_tuser = kind;

  // Checks
  `ASSERT_NEVER(a_queue_overflow, clk, rst, q_wr && q_status.full)
  `ASSERT_IMPLIES(a_err_clean, clk, rst, m_tvalid && kind, (m_tdata[10:0] == 11'd0) && !m_tlast)
  `ASSERT_IMPLIES(a_sample_clean, clk, rst, m_tvalid && !kind, (error_code == ERR_MAGIC) && (channel != 2'd3))
  `ASSERT_IMPLIES(a_eoi_is_eor, clk, rst, m_tvalid && m_tlast, end_of_row && (channel == CH_BLUE))

endmodule
